/* rtl/tmbc_pkg.sv */
// ----------------------------------------------------------------------------
// tmbc_pkg
// Shared types and fixed field widths of the tile map box collision block.
// ----------------------------------------------------------------------------
package tmbc_pkg;

	// Fixed widths of the item fields and the configuration port.
	localparam int OP_W       = 2;
	localparam int ROW_W      = 6;
	localparam int COL_W      = 6;
	localparam int CODE_W     = 8;
	localparam int POS_W      = 17;
	localparam int SIZE_W     = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_BOX   = 2'd1;
	localparam logic [OP_W-1:0] OP_POINT = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [SIZE_W-1:0] ROWS_RESET  = 7'd64;
	localparam logic [SIZE_W-1:0] COLS_RESET  = 7'd64;
	localparam logic [CODE_W-1:0] EMPTY_RESET = 8'd0;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_RANGE,
		ST_READ,
		ST_CHECK,
		ST_FIN
	} tmbc_state_t;

endpackage

/* rtl/tmbc_cdiv.sv */
// ----------------------------------------------------------------------------
// tmbc_cdiv
// Pipelined unsigned division by a constant: reciprocal multiply, one
// multiply back and a single correction step.
// ----------------------------------------------------------------------------
module tmbc_cdiv #(
	parameter int NW      = 18,
	parameter int DIVISOR = 32
) (
	input  logic          clk,
	input  logic [NW-1:0] n,
	output logic [NW-1:0] q
);

	// The estimate floor(n * M / 2^SH) is either the quotient or one less.
	localparam int    SH    = NW + $clog2(DIVISOR);
	localparam int    MW    = NW + 1;
	localparam int    PW    = NW + MW;
	localparam longint MUL  = (longint'(1) << SH) / DIVISOR;
	localparam logic [MW-1:0] MUL_V = MW'(MUL);
	localparam logic [NW-1:0] DIV_V = NW'(DIVISOR);

	logic [PW-1:0] prod_s1;
	logic [NW-1:0] n_s1;
	logic [NW-1:0] qe;
	logic [NW-1:0] qe_s2;
	logic [NW-1:0] back_s2;
	logic [NW-1:0] n_s2;
	logic [NW-1:0] q_s3;

	assign qe = NW'(prod_s1 >> SH);

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(n) * PW'(MUL_V);
		n_s1    <= n;
		qe_s2   <= qe;
		back_s2 <= qe * DIV_V;
		n_s2    <= n_s1;
		q_s3    <= qe_s2 + NW'((n_s2 - back_s2) >= DIV_V);
	end

	assign q = q_s3;

endmodule

/* rtl/tile_map_box_collision.sv */
// ----------------------------------------------------------------------------
// tile_map_box_collision
// Tile occupancy map with box and point collision queries.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                   Direction  Transfer when
// input     in_valid/in_ready, op, row, col,          in         in_valid & in_ready
//           tile_value, pos_x, pos_y
// result    out_valid/out_ready, hit, out_of_range    out        out_valid & out_ready
// config    cfg_we, cfg_index, cfg_data               in         cfg_we
//
// One item is in work at a time. A write or an unused op goes from its transfer
// straight to the final state. A query is captured, passes the constant
// dividers and then forms the cell range; each cell then takes a read state and
// a compare state on the single map port, for up to four map reads. The map has
// no reset and needs no clearing; reset only returns the sequencer and the
// registers to their defaults. A held result stalls the sequencer in its final
// state only once the next result is ready.
//
module tile_map_box_collision #(
	parameter int TILE_PIXELS = 32,
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLS    = 64,
	parameter int FRAC_BITS   = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [tmbc_pkg::OP_W-1:0]             op,
	input  logic [tmbc_pkg::ROW_W-1:0]            row,
	input  logic [tmbc_pkg::COL_W-1:0]            col,
	input  logic [tmbc_pkg::CODE_W-1:0]           tile_value,
	input  logic signed [tmbc_pkg::POS_W-1:0]     pos_x,
	input  logic signed [tmbc_pkg::POS_W-1:0]     pos_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  hit,
	output logic                                  out_of_range,
	input  logic                                  cfg_we,
	input  logic [tmbc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tmbc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// Box edges are formed at doubled resolution: 2*pos +/- TILE_PIXELS*2^FRAC.
	localparam int HALF2 = TILE_PIXELS << FRAC_BITS;
	localparam int HB    = $clog2(HALF2 + 1);
	localparam int SUMW  = ((HB + 1 > tmbc_pkg::POS_W + 1) ? HB + 1 : tmbc_pkg::POS_W + 1) + 1;
	localparam int NW    = SUMW - 1;
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int LR    = $clog2(MAX_ROWS + 1);
	localparam int LC    = $clog2(MAX_COLS + 1);
	localparam int LW0   = (LR > tmbc_pkg::SIZE_W) ? LR : tmbc_pkg::SIZE_W;
	localparam int LW    = (LC > LW0) ? LC : LW0;

	localparam logic signed [SUMW-1:0] HALF2_S     = SUMW'(HALF2);
	localparam logic signed [SUMW-1:0] NEG_HALF2_S = -HALF2_S;
	localparam logic signed [SUMW-1:0] SCALE_S     = SUMW'(1 << (FRAC_BITS + 1));
	localparam logic signed [SUMW-1:0] ONE_S       = SUMW'(1);
	localparam logic [AW-1:0] COLS_A = AW'(MAX_COLS);
	localparam logic [LW-1:0] MAXR_L = LW'(MAX_ROWS);
	localparam logic [LW-1:0] MAXC_L = LW'(MAX_COLS);

	// Divider lanes: low and high edge per axis; a point query uses the low lanes.
	localparam int LN_XLO = 0;
	localparam int LN_XHI = 1;
	localparam int LN_YLO = 2;
	localparam int LN_YHI = 3;
	localparam int LANES  = 4;

	tmbc_pkg::tmbc_state_t state_q, state_d;

	// Configuration registers.
	logic [tmbc_pkg::SIZE_W-1:0] rows_in_use_q;
	logic [tmbc_pkg::SIZE_W-1:0] cols_in_use_q;
	logic [tmbc_pkg::CODE_W-1:0] empty_code_q;

	// Captured query.
	logic [tmbc_pkg::OP_W-1:0] op_q;
	logic [NW-1:0] n_q [LANES];
	logic [NW-1:0] quo [LANES];
	logic x_hok_q, y_hok_q, x_neg_q, y_neg_q, x_far_q, y_far_q;

	// Cell walk.
	logic [RIW-1:0] r0_q, r1_q, r_q;
	logic [CIW-1:0] c0_q, c1_q, c_q;
	logic [1:0]     div_cnt_q;

	// Results.
	logic res_hit_q, res_oor_q;
	logic out_valid_q, hit_q, oor_q;

	// Map memory.
	logic [tmbc_pkg::CODE_W-1:0] tile_mem [DEPTH];
	logic [tmbc_pkg::CODE_W-1:0] rdata_q;
	logic [AW-1:0] wr_addr, rd_addr, mem_addr;
	logic          mem_we;

	logic in_fire, wr_ok;

	// Edge arithmetic at the input.
	logic signed [SUMW-1:0] px_s, py_s, xhi, xlo, yhi, ylo;
	logic [NW-1:0] bx_lo, bx_hi, by_lo, by_hi, pt_x, pt_y;

	// Range forming.
	logic [LW-1:0] effr, effc;
	logic [NW-1:0] effr_n, effc_n, cb, rb, pcx, pcy;
	logic box_x_ok, box_y_ok, pt_oor, is_box, go_read;

	// Sequencer strobes.
	logic load_range, res_clear, res_oor_set, res_hit_set, step_col, step_row, load_out;
	logic last_cell, cell_hit;

	assign in_ready = (state_q == tmbc_pkg::ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q <= tmbc_pkg::ROWS_RESET;
			cols_in_use_q <= tmbc_pkg::COLS_RESET;
			empty_code_q  <= tmbc_pkg::EMPTY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tmbc_pkg::CFG_ROWS:  rows_in_use_q <= cfg_data[tmbc_pkg::SIZE_W-1:0];
				tmbc_pkg::CFG_COLS:  cols_in_use_q <= cfg_data[tmbc_pkg::SIZE_W-1:0];
				tmbc_pkg::CFG_EMPTY: empty_code_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input edge arithmetic. Every value handed to a divider is
	// non-negative; signs are resolved here into flags.
	// ------------------------------------------------------------------
	always_comb begin
		px_s = SUMW'(pos_x);
		py_s = SUMW'(pos_y);
		xhi  = (px_s <<< 1) + HALF2_S;
		xlo  = (px_s <<< 1) - HALF2_S;
		yhi  = (py_s <<< 1) + HALF2_S;
		ylo  = (py_s <<< 1) - HALF2_S;
		// A low edge at or below zero always starts at cell zero.
		bx_lo = (xlo > 0) ? NW'(xlo >>> (FRAC_BITS + 1)) : '0;
		by_lo = (ylo > 0) ? NW'(ylo >>> (FRAC_BITS + 1)) : '0;
		// The last pixel inside the open span is the truncated high edge minus one.
		bx_hi = (xhi >= SCALE_S) ? NW'((xhi >>> (FRAC_BITS + 1)) - ONE_S) : '0;
		by_hi = (yhi >= SCALE_S) ? NW'((yhi >>> (FRAC_BITS + 1)) - ONE_S) : '0;
		pt_x  = (px_s >= 0) ? NW'(px_s >>> FRAC_BITS) : '0;
		pt_y  = (py_s >= 0) ? NW'(py_s >>> FRAC_BITS) : '0;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q    <= op;
			x_hok_q <= (xhi >= SCALE_S);
			y_hok_q <= (yhi >= SCALE_S);
			x_neg_q <= pos_x[tmbc_pkg::POS_W-1];
			y_neg_q <= pos_y[tmbc_pkg::POS_W-1];
			x_far_q <= (px_s <= NEG_HALF2_S);
			y_far_q <= (py_s <= NEG_HALF2_S);
			if (op == tmbc_pkg::OP_BOX) begin
				n_q[LN_XLO] <= bx_lo;
				n_q[LN_XHI] <= bx_hi;
				n_q[LN_YLO] <= by_lo;
				n_q[LN_YHI] <= by_hi;
			end else begin
				n_q[LN_XLO] <= pt_x;
				n_q[LN_XHI] <= '0;
				n_q[LN_YLO] <= pt_y;
				n_q[LN_YHI] <= '0;
			end
		end
	end

	// Four constant dividers by the tile size.
	for (genvar g = 0; g < LANES; g++) begin : g_div
		tmbc_cdiv #(
			.NW      (NW),
			.DIVISOR (TILE_PIXELS)
		) u_cdiv (
			.clk (clk),
			.n   (n_q[g]),
			.q   (quo[g])
		);
	end

	// ------------------------------------------------------------------
	// Cell range. Sizes above the map storage act as the storage size.
	// ------------------------------------------------------------------
	always_comb begin
		effr   = (LW'(rows_in_use_q) > MAXR_L) ? MAXR_L : LW'(rows_in_use_q);
		effc   = (LW'(cols_in_use_q) > MAXC_L) ? MAXC_L : LW'(cols_in_use_q);
		effr_n = NW'(effr);
		effc_n = NW'(effc);
		cb = (quo[LN_XHI] > effc_n - NW'(1)) ? effc_n - NW'(1) : quo[LN_XHI];
		rb = (quo[LN_YHI] > effr_n - NW'(1)) ? effr_n - NW'(1) : quo[LN_YHI];
		box_x_ok = x_hok_q && (effc_n != '0) && (quo[LN_XLO] <= cb);
		box_y_ok = y_hok_q && (effr_n != '0) && (quo[LN_YLO] <= rb);
		// A point between minus one tile and zero truncates to cell zero.
		pcx    = x_neg_q ? '0 : quo[LN_XLO];
		pcy    = y_neg_q ? '0 : quo[LN_YLO];
		pt_oor = x_far_q || y_far_q || (pcx >= effc_n) || (pcy >= effr_n);
		is_box = (op_q == tmbc_pkg::OP_BOX);
		go_read = is_box ? (box_x_ok && box_y_ok) : !pt_oor;
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	assign last_cell = (c_q == c1_q) && (r_q == r1_q);
	assign cell_hit  = (rdata_q != empty_code_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmbc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		load_range  = 1'b0;
		res_clear   = 1'b0;
		res_oor_set = 1'b0;
		res_hit_set = 1'b0;
		step_col    = 1'b0;
		step_row    = 1'b0;
		load_out    = 1'b0;
		unique case (state_q)
			tmbc_pkg::ST_IDLE: begin
				if (in_fire) begin
					res_clear = 1'b1;
					if (op == tmbc_pkg::OP_BOX || op == tmbc_pkg::OP_POINT) begin
						state_d = tmbc_pkg::ST_DIV;
					end else begin
						state_d = tmbc_pkg::ST_FIN;
					end
				end
			end
			tmbc_pkg::ST_DIV: begin
				if (div_cnt_q == 2'd2) begin
					state_d = tmbc_pkg::ST_RANGE;
				end
			end
			tmbc_pkg::ST_RANGE: begin
				load_range = 1'b1;
				if (go_read) begin
					state_d = tmbc_pkg::ST_READ;
				end else begin
					res_oor_set = !is_box;
					state_d     = tmbc_pkg::ST_FIN;
				end
			end
			tmbc_pkg::ST_READ: begin
				state_d = tmbc_pkg::ST_CHECK;
			end
			tmbc_pkg::ST_CHECK: begin
				if (cell_hit) begin
					res_hit_set = 1'b1;
					state_d     = tmbc_pkg::ST_FIN;
				end else if (last_cell) begin
					state_d = tmbc_pkg::ST_FIN;
				end else begin
					step_col = (c_q != c1_q);
					step_row = (c_q == c1_q);
					state_d  = tmbc_pkg::ST_READ;
				end
			end
			tmbc_pkg::ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = tmbc_pkg::ST_IDLE;
				end
			end
			default: state_d = tmbc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			res_hit_q <= 1'b0;
			res_oor_q <= 1'b0;
		end else begin
			div_cnt_q <= (state_q == tmbc_pkg::ST_DIV) ? div_cnt_q + 2'd1 : 2'd0;
			if (res_clear) begin
				res_hit_q <= 1'b0;
				res_oor_q <= 1'b0;
			end
			if (res_oor_set) begin
				res_oor_q <= 1'b1;
			end
			if (res_hit_set) begin
				res_hit_q <= 1'b1;
			end
		end
	end

	// Walk the covered cells row by row. Indices were checked against the map
	// size before they are cut down to index width.
	always_ff @(posedge clk) begin
		if (load_range) begin
			c0_q <= CIW'(is_box ? quo[LN_XLO] : pcx);
			c1_q <= CIW'(is_box ? cb : pcx);
			r0_q <= RIW'(is_box ? quo[LN_YLO] : pcy);
			r1_q <= RIW'(is_box ? rb : pcy);
			c_q  <= CIW'(is_box ? quo[LN_XLO] : pcx);
			r_q  <= RIW'(is_box ? quo[LN_YLO] : pcy);
		end else if (step_col) begin
			c_q <= c_q + CIW'(1);
		end else if (step_row) begin
			c_q <= c0_q;
			r_q <= r_q + RIW'(1);
		end
	end

	// ------------------------------------------------------------------
	// Map memory: one port, write on a write transfer inside the storage, read otherwise.
	// ------------------------------------------------------------------
	assign wr_ok    = (LW'(row) < MAXR_L) && (LW'(col) < MAXC_L);
	assign mem_we   = in_fire && (op == tmbc_pkg::OP_WRITE) && wr_ok;
	assign wr_addr  = AW'(row) * COLS_A + AW'(col);
	assign rd_addr  = AW'(r_q) * COLS_A + AW'(c_q);
	assign mem_addr = mem_we ? wr_addr : rd_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tile_mem[mem_addr] <= tile_value;
		end
		rdata_q <= tile_mem[mem_addr];
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			hit_q <= res_hit_q;
			oor_q <= res_oor_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign out_of_range = oor_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_write_skips_query : assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (op == tmbc_pkg::OP_WRITE) |=> state_q == tmbc_pkg::ST_FIN)
		else $error("write transfer did not go straight to the result");

	a_walk_in_range : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tmbc_pkg::ST_READ) |->
			(c_q >= c0_q) && (c_q <= c1_q) && (r_q >= r0_q) && (r_q <= r1_q))
		else $error("cell walk left its range");

	a_hit_excl_oor : assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !(res_hit_q && res_oor_q))
		else $error("result flags hit and out of range together");

	a_read_in_map : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tmbc_pkg::ST_READ) |->
			(LW'(r1_q) < MAXR_L) && (LW'(c1_q) < MAXC_L))
		else $error("map read beyond storage");

endmodule
